// File: rtl/ppe_pkg.sv
package ppe_pkg;

  localparam int MaxParticles = 64;
  localparam logic [23:0] AgeReset = 24'd65536;

  localparam logic [1:0] ACT_SPAWN = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_DRAW  = 2'd3;

  localparam logic [2:0] REG_ACTIVE_SLOTS = 3'd0;
  localparam logic [2:0] REG_GRAVITY_Y    = 3'd1;
  localparam logic [2:0] REG_PALETTE_0    = 3'd2;
  localparam logic [2:0] REG_PALETTE_3    = 3'd5;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [23:0]        life;
    logic [7:0]         size;
    logic [7:0]         palette_index;
    logic [15:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_right;
    logic signed [15:0] rect_bottom;
    logic [31:0]        fill_color;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_GDT,
    ST_READ,
    ST_WAIT,
    ST_VY,
    ST_PX,
    ST_PY,
    ST_WRITE,
    ST_DRAW,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic signed [23:0] a;
    logic [15:0]        dt;
  } mul_req_t;

endpackage

// File: rtl/ppe_ram.sv
module ppe_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ppe_scale.sv
module ppe_scale (
  input  logic              clk,
  input  ppe_pkg::mul_req_t req,
  output logic signed [23:0] scaled
);

  logic signed [40:0] prod;
  logic signed [40:0] prod_q;
  logic signed [40:0] adj;

  assign prod = 41'(req.a) * $signed({25'd0, req.dt});

  // Floor division by 65536 is an arithmetic shift.
  assign adj = prod_q >>> 16;

  always_ff @(posedge clk) begin
    prod_q <= prod;
    scaled <= 24'(adj);
  end

endmodule

// File: rtl/particle_pool_engine.sv
// A spawn is written as it is accepted and the next item may follow at once; a clear sweeps all
// MAX_PARTICLES slots. A tick runs the gravity step, then reads each slot below the clamped
// active_slots count, updates a live one in VY, PX and PY, writes it back and skips an idle one;
// the steps share the one multiplier. A draw visits each slot in DRAW and EMIT and can be
// held by an output stall; one item is worked at a time. Each rectangle waits for the next live
// slot or the flush, which flags the last. Reset is synchronous and clears the lifetime stores.
module particle_pool_engine #(
  parameter int MAX_PARTICLES = ppe_pkg::MaxParticles
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppe_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = AW + 1;

  ppe_pkg::state_t state, state_next;

  logic [6:0]         active_slots;
  logic signed [23:0] gravity_y;
  logic [31:0]        palette [4];

  ppe_pkg::in_item_t  item;
  logic [CW-1:0]      idx;
  logic [AW-1:0]      ring_pointer;
  logic [CW-1:0]      n_slots;
  logic [2:0]         cnt;
  logic signed [23:0] gdt;

  logic [23:0] r_px, r_py, r_vx, r_vy, r_age, r_life;
  logic [7:0]  r_size;
  logic [1:0]  r_pal;
  logic signed [23:0] n_px, n_py, n_vy;
  logic [23:0] n_age;

  logic               we_all, we_life;
  logic [AW-1:0]      waddr;
  logic [23:0]        w_px, w_py, w_vx, w_vy, w_age, w_life;
  logic [7:0]         w_size;
  logic [1:0]         w_pal;

  ppe_pkg::mul_req_t  mreq;
  logic signed [23:0] mres;

  ppe_pkg::out_item_t pend;
  logic               pend_valid;
  logic               emit_take;
  logic               out_load;
  ppe_pkg::out_item_t out_next;

  logic live;
  logic [CW-1:0] spawn_slot;

  always_comb begin
    if (active_slots == 7'd0) begin
      n_slots = CW'(1);
    end else if ({25'd0, active_slots} > 32'(MAX_PARTICLES)) begin
      n_slots = CW'(MAX_PARTICLES);
    end else begin
      n_slots = CW'(active_slots);
    end
  end

  assign spawn_slot = ({1'b0, ring_pointer} >= n_slots) ? '0 : {1'b0, ring_pointer};
  assign live = r_age < r_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= 7'd64;
      gravity_y <= '0;
      for (int i = 0; i < 4; i++) begin
        palette[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppe_pkg::REG_ACTIVE_SLOTS: active_slots <= cfg_data[6:0];
        ppe_pkg::REG_GRAVITY_Y:    gravity_y <= cfg_data[23:0];
        default: begin
          if (cfg_index >= ppe_pkg::REG_PALETTE_0 && cfg_index <= ppe_pkg::REG_PALETTE_3) begin
            palette[2'(cfg_index - ppe_pkg::REG_PALETTE_0)] <= cfg_data;
          end
        end
      endcase
    end
  end

  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_px (.clk, .we(we_all),
    .waddr, .wdata(w_px), .raddr(idx[AW-1:0]), .rdata(r_px));
  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_py (.clk, .we(we_all),
    .waddr, .wdata(w_py), .raddr(idx[AW-1:0]), .rdata(r_py));
  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_vx (.clk, .we(we_all),
    .waddr, .wdata(w_vx), .raddr(idx[AW-1:0]), .rdata(r_vx));
  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_vy (.clk, .we(we_all),
    .waddr, .wdata(w_vy), .raddr(idx[AW-1:0]), .rdata(r_vy));
  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_age (.clk, .we(we_life),
    .waddr, .wdata(w_age), .raddr(idx[AW-1:0]), .rdata(r_age));
  ppe_ram #(.Width(24), .Depth(MAX_PARTICLES)) u_life (.clk, .we(we_life),
    .waddr, .wdata(w_life), .raddr(idx[AW-1:0]), .rdata(r_life));
  ppe_ram #(.Width(8), .Depth(MAX_PARTICLES)) u_size (.clk, .we(we_all),
    .waddr, .wdata(w_size), .raddr(idx[AW-1:0]), .rdata(r_size));
  ppe_ram #(.Width(2), .Depth(MAX_PARTICLES)) u_pal (.clk, .we(we_all),
    .waddr, .wdata(w_pal), .raddr(idx[AW-1:0]), .rdata(r_pal));

  ppe_scale u_scale (.clk, .req(mreq), .scaled(mres));

  always_comb begin
    logic [24:0] asum;
    asum = {1'b0, r_age} + {9'd0, item.step_time};
    n_age = asum[24] ? 24'hFFFFFF : asum[23:0];
  end

  function automatic logic signed [23:0] sat_add(logic signed [23:0] a, logic signed [23:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > 25'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -25'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  function automatic logic signed [15:0] pix16(logic [23:0] q, logic [7:0] s);
    logic signed [23:0] sq;
    logic [23:0]        mag;
    logic signed [17:0] p;
    sq = q;
    mag = sq[23] ? 24'(-sq) : sq;
    p = sq[23] ? -18'(mag[23:8]) : 18'(mag[23:8]);
    p = p + 18'(s);
    if (p > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (p < -18'sd32768) begin
      return 16'sh8000;
    end
    return p[15:0];
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ppe_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          unique case (in_data.action)
            ppe_pkg::ACT_SPAWN: state_next = ppe_pkg::ST_IDLE;
            ppe_pkg::ACT_TICK:  state_next = ppe_pkg::ST_GDT;
            ppe_pkg::ACT_CLEAR: state_next = ppe_pkg::ST_CLEAR;
            default:            state_next = ppe_pkg::ST_DRAW;
          endcase
        end
      end
      ppe_pkg::ST_CLEAR: if (idx == CW'(MAX_PARTICLES - 1)) state_next = ppe_pkg::ST_IDLE;
      ppe_pkg::ST_GDT:   if (cnt == 3'd2) state_next = ppe_pkg::ST_READ;
      ppe_pkg::ST_READ: begin
        if (idx >= n_slots) state_next = ppe_pkg::ST_IDLE;
        else state_next = ppe_pkg::ST_WAIT;
      end
      ppe_pkg::ST_WAIT:  state_next = live ? ppe_pkg::ST_VY : ppe_pkg::ST_READ;
      ppe_pkg::ST_VY:    if (cnt == 3'd2) state_next = ppe_pkg::ST_PX;
      ppe_pkg::ST_PX:    if (cnt == 3'd2) state_next = ppe_pkg::ST_PY;
      ppe_pkg::ST_PY:    if (cnt == 3'd2) state_next = ppe_pkg::ST_WRITE;
      ppe_pkg::ST_WRITE: state_next = ppe_pkg::ST_READ;
      ppe_pkg::ST_DRAW: begin
        if (idx >= n_slots) state_next = ppe_pkg::ST_FLUSH;
        else state_next = ppe_pkg::ST_EMIT;
      end
      ppe_pkg::ST_EMIT: begin
        if (!live) state_next = ppe_pkg::ST_DRAW;
        else if (!pend_valid || !out_valid || !out_stall) state_next = ppe_pkg::ST_DRAW;
      end
      ppe_pkg::ST_FLUSH: if (!out_valid || !out_stall) state_next = ppe_pkg::ST_IDLE;
      default: state_next = ppe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ppe_pkg::ST_IDLE) || out_valid;
    mreq.a = gravity_y;
    mreq.dt = item.step_time;
    unique case (state)
      ppe_pkg::ST_VY: mreq.a = r_vx;
      ppe_pkg::ST_PX: mreq.a = n_vy;
      default:        mreq.a = gravity_y;
    endcase
    we_all = 1'b0;
    we_life = 1'b0;
    waddr = idx[AW-1:0];
    w_px = n_px;
    w_py = n_py;
    w_vx = r_vx;
    w_vy = n_vy;
    w_age = n_age;
    w_life = r_life;
    w_size = r_size;
    w_pal = r_pal;
    unique case (state)
      ppe_pkg::ST_IDLE: begin
        if (in_valid && !in_stall && in_data.action == ppe_pkg::ACT_SPAWN
            && in_data.life != 24'd0) begin
          we_all = 1'b1;
          we_life = 1'b1;
          waddr = spawn_slot[AW-1:0];
          w_px = in_data.pos_x;
          w_py = in_data.pos_y;
          w_vx = in_data.vel_x;
          w_vy = in_data.vel_y;
          w_age = '0;
          w_life = in_data.life;
          w_size = (in_data.size == 8'd0) ? 8'd1 : in_data.size;
          w_pal = in_data.palette_index[1:0];
        end
      end
      ppe_pkg::ST_CLEAR: begin
        we_life = 1'b1;
        w_age = ppe_pkg::AgeReset;
        w_life = '0;
      end
      ppe_pkg::ST_WRITE: begin
        we_all = 1'b1;
        we_life = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    emit_take = (state == ppe_pkg::ST_EMIT) && live
                && (!pend_valid || !out_valid || !out_stall);
    out_load = pend_valid && (emit_take || ((state == ppe_pkg::ST_FLUSH)
               && (!out_valid || !out_stall)));
    out_next = pend;
    out_next.last = (state == ppe_pkg::ST_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppe_pkg::ST_CLEAR;
      idx <= '0;
      cnt <= '0;
      ring_pointer <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        out_data <= out_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ppe_pkg::ST_IDLE: begin
          idx <= '0;
          cnt <= '0;
          pend_valid <= 1'b0;
          if (in_valid && !in_stall) begin
            item <= in_data;
            if (in_data.action == ppe_pkg::ACT_SPAWN && in_data.life != 24'd0) begin
              ring_pointer <= (spawn_slot + CW'(1) >= n_slots) ? '0
                            : AW'(spawn_slot + CW'(1));
            end
          end
        end
        ppe_pkg::ST_CLEAR: idx <= idx + CW'(1);
        ppe_pkg::ST_GDT: begin
          cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
          if (cnt == 3'd2) gdt <= mres;
        end
        ppe_pkg::ST_WAIT: if (!live) idx <= idx + CW'(1);
        ppe_pkg::ST_VY: begin
          cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
          if (cnt == 3'd0) n_vy <= sat_add(r_vy, gdt);
          if (cnt == 3'd2) n_px <= sat_add(r_px, mres);
        end
        ppe_pkg::ST_PX: begin
          cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
          if (cnt == 3'd2) n_py <= sat_add(r_py, mres);
        end
        ppe_pkg::ST_PY: cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
        ppe_pkg::ST_WRITE: idx <= idx + CW'(1);
        ppe_pkg::ST_EMIT: begin
          if (emit_take) begin
            pend_valid <= 1'b1;
            pend.rect_left <= pix16(r_px, 8'd0);
            pend.rect_top <= pix16(r_py, 8'd0);
            pend.rect_right <= pix16(r_px, r_size);
            pend.rect_bottom <= pix16(r_py, r_size);
            pend.fill_color <= palette[r_pal];
            pend.last <= 1'b0;
          end
          if (!live || emit_take) idx <= idx + CW'(1);
        end
        ppe_pkg::ST_FLUSH: begin
          if (!out_valid || !out_stall) pend_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/ppe_checker.sv
module ppe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ppe_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ppe_pkg::out_item_t out_data
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("Input taken while a result beat is pending.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.action != ppe_pkg::ACT_SPAWN |=> in_stall)
    else $error("Second item taken straight after a multi-cycle item.");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat shown out of reset.");

endmodule

bind particle_pool_engine ppe_checker u_ppe_checker (
  .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);

// File: verif/particle_pool_engine_test.sv
`timescale 1ns / 100ps

module particle_pool_engine_test;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ppe_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ppe_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  particle_pool_engine u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [6:0] slots_reg;
  logic signed [23:0] gravity;
  logic [31:0] palette [4];
  logic signed [23:0] px [64], py [64], vx [64], vy [64];
  logic [23:0] age [64], life_left [64];
  logic [7:0] side [64];
  logic [1:0] colour_sel [64];
  int ring;

  ppe_pkg::out_item_t rect_queue [$];
  bit failed = 1'b0;
  bit calm = 1'b0;
  int cycles = 0;

  function automatic int slot_count();
    if (slots_reg == 0) return 1;
    if (slots_reg > 64) return 64;
    return slots_reg;
  endfunction

  function automatic longint floor_scale(logic signed [23:0] a, logic [15:0] dt);
    longint p;
    p = longint'(a) * longint'({1'b0, dt});
    if (p >= 0) return p >>> 16;
    return -((-p + 65535) >>> 16);
  endfunction

  function automatic logic signed [23:0] sat24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic int pixel(logic signed [23:0] q);
    int v;
    v = q;
    if (v >= 0) return v / 256;
    return -((-v) / 256);
  endfunction

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic predict(ppe_pkg::in_item_t it);
    int n, s, x, y, cnt;
    longint g;
    logic [24:0] a;
    ppe_pkg::out_item_t r;
    n = slot_count();
    case (it.action)
      ppe_pkg::ACT_SPAWN: begin
        if (it.life != 0) begin
          s = (ring >= n) ? 0 : ring;
          ring = (s + 1 >= n) ? 0 : s + 1;
          px[s] = it.pos_x; py[s] = it.pos_y; vx[s] = it.vel_x; vy[s] = it.vel_y;
          age[s] = 0; life_left[s] = it.life;
          side[s] = (it.size == 0) ? 8'd1 : it.size;
          colour_sel[s] = it.palette_index[1:0];
        end
      end
      ppe_pkg::ACT_TICK: begin
        g = floor_scale(gravity, it.step_time);
        for (int i = 0; i < n; i++) begin
          if (age[i] < life_left[i]) begin
            a = age[i] + it.step_time;
            age[i] = a[24] ? 24'hffffff : a[23:0];
            vy[i] = sat24(longint'(vy[i]) + g);
            px[i] = sat24(longint'(px[i]) + floor_scale(vx[i], it.step_time));
            py[i] = sat24(longint'(py[i]) + floor_scale(vy[i], it.step_time));
          end
        end
      end
      ppe_pkg::ACT_CLEAR: begin
        for (int i = 0; i < 64; i++) begin
          age[i] = ppe_pkg::AgeReset; life_left[i] = 0;
        end
      end
      default: begin
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          if (age[i] < life_left[i]) begin
            x = pixel(px[i]); y = pixel(py[i]);
            r.rect_left = clamp16(x);
            r.rect_top = clamp16(y);
            r.rect_right = clamp16(x + side[i]);
            r.rect_bottom = clamp16(y + side[i]);
            r.fill_color = palette[colour_sel[i]];
            r.last = 1'b0;
            rect_queue.push_back(r);
            cnt++;
          end
        end
        if (cnt > 0) rect_queue[$].last = 1'b1;
      end
    endcase
  endtask

  // The valid line is dropped by the next idle cycle or by the caller that follows.
  task automatic send_item(ppe_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    @(negedge clk);
    while (rect_queue.size() != 0 || in_stall) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ppe_pkg::REG_ACTIVE_SLOTS) slots_reg = val[6:0];
    else if (idx == ppe_pkg::REG_GRAVITY_Y) gravity = val[23:0];
    else if (idx >= ppe_pkg::REG_PALETTE_0 && idx <= ppe_pkg::REG_PALETTE_3)
      palette[2'(idx - ppe_pkg::REG_PALETTE_0)] = val;
  endtask

  function automatic ppe_pkg::in_item_t random_item(logic [1:0] act);
    ppe_pkg::in_item_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(ppe_pkg::in_item_t)-1:0];
    it.action = act;
    if (act == ppe_pkg::ACT_SPAWN) begin
      if ($urandom_range(3) != 0) begin
        it.pos_x = 24'(int'($urandom_range(0, 40000)) - 20000);
        it.pos_y = 24'(int'($urandom_range(0, 40000)) - 20000);
        it.vel_x = 24'(int'($urandom_range(0, 8000)) - 4000);
        it.vel_y = 24'(int'($urandom_range(0, 8000)) - 4000);
      end
      if ($urandom_range(9) == 0) it.life = 0;
    end
    return it;
  endfunction

  task automatic spawn(int x, int y, int vxi, int vyi, int lf, int sz, int pal);
    ppe_pkg::in_item_t it;
    it = '0;
    it.action = ppe_pkg::ACT_SPAWN;
    it.pos_x = 24'(x); it.pos_y = 24'(y); it.vel_x = 24'(vxi); it.vel_y = 24'(vyi);
    it.life = 24'(lf); it.size = 8'(sz); it.palette_index = 8'(pal);
    send_item(it);
  endtask

  task automatic simple(logic [1:0] act, logic [15:0] dt);
    ppe_pkg::in_item_t it;
    it = '0;
    it.action = act;
    it.step_time = dt;
    send_item(it);
  endtask

  task automatic test_registers();
    write_reg(ppe_pkg::REG_PALETTE_0, 32'hffffffff);
    write_reg(ppe_pkg::REG_PALETTE_0 + 3'd1, 32'h12345678);
    write_reg(ppe_pkg::REG_PALETTE_0 + 3'd2, 32'h00000000);
    write_reg(ppe_pkg::REG_PALETTE_3, 32'ha5c3_0f81);
    write_reg(ppe_pkg::REG_GRAVITY_Y, 32'h00000100);
    write_reg(ppe_pkg::REG_ACTIVE_SLOTS, 32'd64);
  endtask

  task automatic test_extremes();
    simple(ppe_pkg::ACT_DRAW, 0);
    spawn(8388607, -8388608, 8388607, -8388608, 24'hffffff, 255, 255);
    spawn(-8388608, 8388607, -8388608, 8388607, 1, 0, 2);
    spawn(-300, 300, 0, 0, 0, 7, 1);
    spawn(-257, 255, 100, -100, 65536, 1, 1);
    spawn(0, 0, 0, 0, 200000, 128, 0);
    simple(ppe_pkg::ACT_DRAW, 0);
    simple(ppe_pkg::ACT_TICK, 16'hffff);
    simple(ppe_pkg::ACT_DRAW, 0);
    simple(ppe_pkg::ACT_TICK, 0);
    simple(ppe_pkg::ACT_TICK, 1);
    simple(ppe_pkg::ACT_DRAW, 0);
    simple(ppe_pkg::ACT_CLEAR, 0);
    simple(ppe_pkg::ACT_DRAW, 0);
  endtask

  task automatic test_small_pool();
    write_reg(ppe_pkg::REG_ACTIVE_SLOTS, 32'd0);
    spawn(1000, 1000, 5, 5, 1000, 3, 3);
    spawn(2000, 2000, 5, 5, 1000, 3, 2);
    simple(ppe_pkg::ACT_DRAW, 0);
    write_reg(ppe_pkg::REG_ACTIVE_SLOTS, 32'd3);
    spawn(100, 100, 1, 1, 1000, 4, 1);
    spawn(200, 200, 1, 1, 1000, 4, 1);
    write_reg(ppe_pkg::REG_ACTIVE_SLOTS, 32'd1);
    spawn(300, 300, 1, 1, 1000, 4, 0);
    simple(ppe_pkg::ACT_DRAW, 0);
    write_reg(ppe_pkg::REG_ACTIVE_SLOTS, 32'd127);
    simple(ppe_pkg::ACT_DRAW, 0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [1:0] act;
    for (int k = 0; k < count; k++) begin
      calm = (k >= count / 3 && k < count / 2);
      r = $urandom_range(99);
      act = (r < 55) ? ppe_pkg::ACT_SPAWN : (r < 80) ? ppe_pkg::ACT_TICK
          : (r < 83) ? ppe_pkg::ACT_CLEAR : ppe_pkg::ACT_DRAW;
      send_item(random_item(act));
      if (k % 60 == 59) begin
        write_reg(ppe_pkg::REG_ACTIVE_SLOTS, $urandom_range(1, 64));
        write_reg(ppe_pkg::REG_GRAVITY_Y, (k % 120 == 59) ? 32'h00800000 : 32'h007fffff);
        write_reg(ppe_pkg::REG_PALETTE_0 + 3'($urandom_range(3)), $urandom);
      end
    end
    calm = 1'b0;
    simple(ppe_pkg::ACT_DRAW, 0);
  endtask

  always @(negedge clk) begin
    if (rst || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    ppe_pkg::out_item_t exp_rect;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** particle_pool_engine: FAILED **");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (rect_queue.size() == 0) begin
        $display("%0t: unexpected beat %p", $realtime, out_data);
        failed = 1'b1;
      end else begin
        exp_rect = rect_queue.pop_front();
        if (out_data !== exp_rect) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_rect, out_data);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    slots_reg = 64; gravity = 0; ring = 0;
    for (int i = 0; i < 4; i++) palette[i] = 0;
    for (int i = 0; i < 64; i++) begin
      px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; side[i] = 0; colour_sel[i] = 0;
      age[i] = ppe_pkg::AgeReset; life_left[i] = 0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_registers();
    test_extremes();
    test_small_pool();
    test_random(200);
    in_valid <= 1'b0;
    while (rect_queue.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (!failed) begin
      $display("** particle_pool_engine: PASSED **");
    end else begin
      $display("** particle_pool_engine: FAILED **");
    end
    $finish;
  end

endmodule
